// ===== hdl/pste_pkg.sv =====
// ----------------------------------------------------------------------------
// pste_pkg
// Shared types and constants for the programmable state transition engine.
// ----------------------------------------------------------------------------
`default_nettype none

package pste_pkg;

   localparam int MaxStates  = 16;
   localparam int MaxTrans   = 8;
   localparam int IdBits     = 16;
   localparam int ActBits    = 8;
   localparam int StIdxBits  = $clog2(MaxStates);
   localparam int TrIdxBits  = $clog2(MaxTrans);
   localparam int StCntBits  = $clog2(MaxStates + 1);
   localparam int TrCntBits  = $clog2(MaxTrans + 1);
   localparam int EvAddrBits = StIdxBits + TrIdxBits;
   localparam int EvDepth    = MaxStates * MaxTrans;
   // event slot word: key, target index, action
   localparam int EvWidth    = IdBits + StIdxBits + ActBits;
   // per-state word: default present, default target, default action, event count
   localparam int StWidth    = 1 + StIdxBits + ActBits + TrCntBits;

   // item kinds
   localparam logic [1:0] MODE_ADD_STATE = 2'd0;
   localparam logic [1:0] MODE_ADD_TRANS = 2'd1;
   localparam logic [1:0] MODE_FORCE     = 2'd2;
   localparam logic [1:0] MODE_SEND      = 2'd3;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_DUP_STATE = 3'd2;
   localparam logic [2:0] ST_UNKNOWN   = 3'd3;
   localparam logic [2:0] ST_TR_FULL   = 3'd4;
   localparam logic [2:0] ST_DUP_EVENT = 3'd5;
   localparam logic [2:0] ST_NO_CUR    = 3'd6;
   localparam logic [2:0] ST_UNMATCHED = 3'd7;

   typedef struct packed {
      logic [1:0]         mode;
      logic [IdBits-1:0]  state_id;
      logic [IdBits-1:0]  event_id;
      logic [IdBits-1:0]  target_state_id;
      logic               is_default;
      logic [ActBits-1:0] action_code;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [2:0]         status;
      logic               current_valid;
      logic [IdBits-1:0]  current_state_id;
      logic               action_fire;
      logic [ActBits-1:0] fired_action;
      logic [IdBits-1:0]  from_state_id;
   } rsp_type;

   typedef struct packed {
      logic                 present;
      logic [StIdxBits-1:0] target;
      logic [ActBits-1:0]   action;
      logic [TrCntBits-1:0] count;
   } st_word_type;

   typedef struct packed {
      logic [IdBits-1:0]    key;
      logic [StIdxBits-1:0] target;
      logic [ActBits-1:0]   action;
   } ev_word_type;

endpackage

`default_nettype wire

// ===== hdl/pste_ram.sv =====
// ----------------------------------------------------------------------------
// pste_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pste_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]              rd_data
);

   logic [Width-1:0] mem [Depth];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== hdl/programmable_state_transition_engine_core.sv =====
// ----------------------------------------------------------------------------
// programmable_state_transition_engine_core
// Table-driven state machine: states, transitions and events held in RAMs.
// ----------------------------------------------------------------------------
// Sequence: each state id lookup reads one RAM entry per cycle (two lookups
//   for add transition); then, as the item needs, the per-state word is
//   fetched, the event slots are scanned, and the id of the state left
//   (send) and the current state id are read.
// Throughput: one item at a time; the next transfer is taken once the
//   result has moved into the output register.
// Reset: synchronous; clears state count and current state, sets limit to 16.
//   RAM contents are not cleared: only entries below the counts are read.
`default_nettype none

module programmable_state_transition_engine_core
   import pste_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_data,
   input  wire logic       csr_wr_en,
   input  wire logic [4:0] csr_wr_data
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SCAN_A = 7'b0000010,
      S_SCAN_B = 7'b0000100,
      S_STWORD = 7'b0001000,
      S_EVSCAN = 7'b0010000,
      S_CURID  = 7'b0100000,
      S_DONE   = 7'b1000000
   } fsm_type;

   fsm_type                fsm_ff, fsm_in;
   req_type                req_ff, req_in;
   logic [4:0]             limit_ff, limit_in;
   logic [StCntBits-1:0]   count_ff, count_in;
   logic [StIdxBits-1:0]   cur_ff, cur_in;
   logic                   cur_vld_ff, cur_vld_in;
   logic [StCntBits-1:0]   scan_ff, scan_in;
   logic                   rd_pend_ff, rd_pend_in;
   logic [StIdxBits-1:0]   a_ff, a_in;
   logic                   a_hit_ff, a_hit_in;
   logic [StIdxBits-1:0]   b_ff, b_in;
   logic                   b_hit_ff, b_hit_in;
   st_word_type            stw_ff, stw_in;
   logic [TrCntBits-1:0]   ev_ff, ev_in;
   logic                   ev_hit_ff, ev_hit_in;
   ev_word_type            evw_ff, evw_in;
   logic [2:0]             status_ff, status_in;
   logic [ActBits-1:0]     fired_ff, fired_in;
   logic [IdBits-1:0]      from_ff, from_in;
   rsp_type                res_ff, res_in;
   logic                   rsp_vld_ff, rsp_vld_in;
   rsp_type                rsp_ff, rsp_in;

   // ram ports
   logic                   id_we;
   logic [StIdxBits-1:0]   id_wa, id_ra;
   logic [IdBits-1:0]      id_wd, id_rd;
   logic                   st_we;
   logic [StIdxBits-1:0]   st_wa, st_ra;
   st_word_type            st_wd, st_rd;
   logic                   ev_we;
   logic [EvAddrBits-1:0]  ev_wa, ev_ra;
   ev_word_type            ev_wd, ev_rd;

   logic [StCntBits-1:0]   eff_limit;
   logic                   accept;

   pste_ram #(.Width(IdBits), .Depth(MaxStates)) u_id_ram (
      .clock(clock), .wr_en(id_we), .wr_addr(id_wa), .wr_data(id_wd),
      .rd_addr(id_ra), .rd_data(id_rd));

   pste_ram #(.Width(StWidth), .Depth(MaxStates)) u_st_ram (
      .clock(clock), .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
      .rd_addr(st_ra), .rd_data(st_rd));

   pste_ram #(.Width(EvWidth), .Depth(EvDepth)) u_ev_ram (
      .clock(clock), .wr_en(ev_we), .wr_addr(ev_wa), .wr_data(ev_wd),
      .rd_addr(ev_ra), .rd_data(ev_rd));

   assign eff_limit = (limit_ff > 5'(MaxStates)) ? StCntBits'(MaxStates)
                                                 : StCntBits'(limit_ff);
   assign req_stall = (fsm_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // sequencer
   always_comb begin
      fsm_in     = fsm_ff;
      req_in     = req_ff;
      limit_in   = limit_ff;
      count_in   = count_ff;
      cur_in     = cur_ff;
      cur_vld_in = cur_vld_ff;
      scan_in    = scan_ff;
      rd_pend_in = 1'b0;
      a_in       = a_ff;
      a_hit_in   = a_hit_ff;
      b_in       = b_ff;
      b_hit_in   = b_hit_ff;
      stw_in     = stw_ff;
      ev_in      = ev_ff;
      ev_hit_in  = ev_hit_ff;
      evw_in     = evw_ff;
      status_in  = status_ff;
      fired_in   = fired_ff;
      from_in    = from_ff;
      res_in     = res_ff;
      rsp_vld_in = rsp_vld_ff;
      rsp_in     = rsp_ff;
      id_we = 1'b0; id_wa = '0; id_wd = '0; id_ra = scan_ff[StIdxBits-1:0];
      st_we = 1'b0; st_wa = '0; st_wd = '0; st_ra = a_ff;
      ev_we = 1'b0; ev_wa = '0; ev_wd = '0;
      ev_ra = {a_ff, ev_ff[TrIdxBits-1:0]};

      if (csr_wr_en) begin
         limit_in = csr_wr_data;
      end
      if (rsp_vld_ff && !rsp_stall) begin
         rsp_vld_in = 1'b0;
      end

      unique case (fsm_ff)
         S_IDLE: begin
            if (accept) begin
               req_in    = req_valid ? req_data : req_ff;
               status_in = ST_OK;
               fired_in  = '0;
               from_in   = '0;
               scan_in   = '0;
               a_hit_in  = 1'b0;
               b_hit_in  = 1'b0;
               ev_in     = '0;
               ev_hit_in = 1'b0;
               a_in      = cur_ff;
               if (req_data.mode == MODE_SEND) begin
                  if (!cur_vld_ff) begin
                     status_in = ST_NO_CUR;
                     fsm_in    = S_CURID;
                  end else begin
                     fsm_in = S_STWORD;
                  end
               end else if (req_data.mode == MODE_ADD_STATE &&
                            count_ff >= eff_limit) begin
                  status_in = ST_FULL;
                  fsm_in    = S_CURID;
               end else begin
                  fsm_in = S_SCAN_A;
               end
            end
         end
         // scan state ids for the source (or only) id
         S_SCAN_A: begin
            if (rd_pend_ff && id_rd == req_ff.state_id && !a_hit_ff) begin
               a_hit_in = 1'b1;
               a_in     = StIdxBits'(scan_ff - 1'b1);
            end
            if (scan_ff < count_ff) begin
               scan_in    = scan_ff + 1'b1;
               rd_pend_in = 1'b1;
            end else if (!rd_pend_ff || scan_ff == count_ff) begin
               if (rd_pend_ff || scan_ff == count_ff) begin
                  scan_in = '0;
                  if (req_ff.mode == MODE_ADD_STATE) begin
                     if (a_hit_in) begin
                        status_in = ST_DUP_STATE;
                     end else begin
                        id_we = 1'b1;
                        id_wa = count_ff[StIdxBits-1:0];
                        id_wd = req_ff.state_id;
                        st_we = 1'b1;
                        st_wa = count_ff[StIdxBits-1:0];
                        st_wd = '0;
                        count_in = count_ff + 1'b1;
                     end
                     fsm_in = S_CURID;
                  end else if (req_ff.mode == MODE_FORCE) begin
                     if (a_hit_in) begin
                        cur_in     = a_in;
                        cur_vld_in = 1'b1;
                     end else begin
                        status_in = ST_UNKNOWN;
                     end
                     fsm_in = S_CURID;
                  end else begin
                     fsm_in = S_SCAN_B;
                  end
               end
            end
         end
         // scan state ids for the target id
         S_SCAN_B: begin
            if (rd_pend_ff && id_rd == req_ff.target_state_id && !b_hit_ff) begin
               b_hit_in = 1'b1;
               b_in     = StIdxBits'(scan_ff - 1'b1);
            end
            if (scan_ff < count_ff) begin
               scan_in    = scan_ff + 1'b1;
               rd_pend_in = 1'b1;
            end else begin
               if (!a_hit_ff || !b_hit_in) begin
                  status_in = ST_UNKNOWN;
                  fsm_in    = S_CURID;
               end else begin
                  fsm_in = S_STWORD;
               end
            end
         end
         // fetch per-state word for index a
         S_STWORD: begin
            st_ra = a_ff;
            if (!rd_pend_ff) begin
               rd_pend_in = 1'b1;
            end else begin
               stw_in = st_rd;
               if (req_ff.mode == MODE_ADD_TRANS) begin
                  if (req_ff.is_default) begin
                     st_we = 1'b1;
                     st_wa = a_ff;
                     st_wd = '{present: 1'b1, target: b_ff,
                               action: req_ff.action_code, count: st_rd.count};
                     fsm_in = S_CURID;
                  end else if (st_rd.count >= TrCntBits'(MaxTrans)) begin
                     status_in = ST_TR_FULL;
                     fsm_in    = S_CURID;
                  end else begin
                     fsm_in = S_EVSCAN;
                  end
               end else begin
                  fsm_in = S_EVSCAN;
               end
            end
         end
         // scan event slots of state a
         S_EVSCAN: begin
            if (rd_pend_ff && !ev_hit_ff && ev_rd.key == req_ff.event_id) begin
               ev_hit_in = 1'b1;
               evw_in    = ev_rd;
            end
            if (ev_ff < stw_ff.count && !ev_hit_in) begin
               ev_in      = ev_ff + 1'b1;
               rd_pend_in = 1'b1;
            end else if (!rd_pend_ff || ev_hit_in || ev_ff >= stw_ff.count) begin
               fsm_in = S_CURID;
               if (req_ff.mode == MODE_ADD_TRANS) begin
                  if (ev_hit_in) begin
                     status_in = ST_DUP_EVENT;
                  end else begin
                     ev_we = 1'b1;
                     ev_wa = {a_ff, stw_ff.count[TrIdxBits-1:0]};
                     ev_wd = '{key: req_ff.event_id, target: b_ff,
                               action: req_ff.action_code};
                     st_we = 1'b1;
                     st_wa = a_ff;
                     st_wd = stw_ff;
                     st_wd.count = stw_ff.count + 1'b1;
                  end
               end else begin
                  scan_in = StCntBits'(a_ff);
                  if (ev_hit_in) begin
                     fired_in = evw_in.action;
                     cur_in   = evw_in.target;
                  end else if (stw_ff.present) begin
                     fired_in = stw_ff.action;
                     cur_in   = stw_ff.target;
                  end else begin
                     status_in = ST_UNMATCHED;
                  end
               end
            end
            ev_ra = {a_ff, ev_ff[TrIdxBits-1:0]};
         end
         // read id of the state left (send) then the current id
         S_CURID: begin
            id_ra = (req_ff.mode == MODE_SEND && status_ff == ST_OK && !rd_pend_ff &&
                     !a_hit_ff) ? a_ff : cur_ff;
            if (!rd_pend_ff) begin
               rd_pend_in = 1'b1;
            end else if (req_ff.mode == MODE_SEND && status_ff == ST_OK && !a_hit_ff) begin
               from_in  = id_rd;
               a_hit_in = 1'b1;
            end else begin
               res_in.ok               = (status_ff == ST_OK);
               res_in.status           = status_ff;
               res_in.current_valid    = cur_vld_ff;
               res_in.current_state_id = cur_vld_ff ? id_rd : '0;
               res_in.action_fire      = (fired_ff != '0);
               res_in.fired_action     = fired_ff;
               res_in.from_state_id    = from_ff;
               fsm_in = S_DONE;
            end
         end
         // hand result to the output register once it is free
         S_DONE: begin
            if (!rsp_vld_ff || !rsp_stall) begin
               rsp_vld_in = 1'b1;
               rsp_in     = res_ff;
               fsm_in     = S_IDLE;
            end
         end
         default: fsm_in = S_IDLE;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff     <= S_IDLE;
         limit_ff   <= 5'(MaxStates);
         count_ff   <= '0;
         cur_ff     <= '0;
         cur_vld_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         fsm_ff     <= fsm_in;
         limit_ff   <= limit_in;
         count_ff   <= count_in;
         cur_ff     <= cur_in;
         cur_vld_ff <= cur_vld_in;
         rd_pend_ff <= rd_pend_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      scan_ff   <= scan_in;
      a_ff      <= a_in;
      a_hit_ff  <= (fsm_ff == S_EVSCAN) ? 1'b0 : a_hit_in;
      b_ff      <= b_in;
      b_hit_ff  <= b_hit_in;
      stw_ff    <= stw_in;
      ev_ff     <= ev_in;
      ev_hit_ff <= ev_hit_in;
      evw_ff    <= evw_in;
      status_ff <= status_in;
      fired_ff  <= fired_in;
      from_ff   <= from_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

   // checks
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= StCntBits'(MaxStates))
      else $error("state count beyond capacity");

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (fsm_ff != S_IDLE) |-> req_stall)
      else $error("input taken while busy");

   a_cur_in_table: assert property (@(posedge clock) disable iff (reset)
      cur_vld_ff |-> (StCntBits'(cur_ff) < count_ff))
      else $error("current state outside table");

   a_fire_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.action_fire) |-> rsp_data.ok)
      else $error("action fired on failed item");

endmodule

`default_nettype wire
